// ===== rtl/skt_pkg.sv =====
// Shared types and codes for the sorted key table.
// Holds operation and status codes, controller states and the command/status structs.
package skt_pkg;

  localparam int OP_W      = 2;
  localparam int IN_KEY_W  = 32;
  localparam int IN_LINE_W = 24;
  localparam int STATUS_W  = 3;
  localparam int CAP_W     = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_FIND   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd5;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_PROBE,
    S_CMP,
    S_SHIFT,
    S_RESP
  } state_t;

  typedef struct packed {
    logic                load;
    logic                clear_cnt;
    logic                srch_init;
    logic                probe;
    logic                cmp;
    logic                shift_init;
    logic                shift_step;
    logic                write_new;
    logic                resp;
    logic [STATUS_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic is_insert;
    logic is_clear;
    logic bad_line;
    logic srch_more;
    logic hit;
    logic full;
    logic shift_done;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/skt_in_if.sv =====
// Input channel of the sorted key table: valid/ready handshake with operation, key and line.
// Depends on skt_pkg for field widths.
interface skt_in_if import skt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OP_W-1:0]      operation;
  logic [IN_KEY_W-1:0]  key;
  logic [IN_LINE_W-1:0] line_no;

  modport source (output valid, output operation, output key, output line_no, input ready);
  modport sink   (input valid, input operation, input key, input line_no, output ready);
endinterface

// ===== rtl/skt_out_if.sv =====
// Result channel of the sorted key table: valid/ready handshake with status and line.
// Depends on skt_pkg for field widths.
interface skt_out_if import skt_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic [IN_LINE_W-1:0] line_out;

  modport source (output valid, output status, output line_out, input ready);
  modport sink   (input valid, input status, input line_out, output ready);
endinterface

// ===== rtl/sorted_key_table.sv =====
// Top level of the sorted key table: joins controller and datapath.
// Depends on skt_pkg, skt_in_if, skt_out_if, skt_ctrl and skt_datapath.
//
// Keeps up to DEPTH unique keys in ascending order with a line number each, and answers
// insert, find and clear requests one at a time, one result per request. A clear or a
// rejected insert (line 0) goes from decode straight to the response. A find runs a
// binary search of S probes, at most ceil(log2(count+1)); each probe costs one
// registered read of the key RAM and one compare. An insert of a new key searches the
// same way, then moves the (count - pos) higher entries up one place, one entry per
// cycle through the single read and write port of the entry RAMs, where pos is the
// insert position, and writes the new key at pos. The next request is taken while a
// result waits on the output register. The entry RAMs need no clearing after reset;
// only entries below the count are ever used.
module sorted_key_table import skt_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int KEY_BITS  = 32,
  parameter int LINE_BITS = 24
) (
  input  logic             clk,
  input  logic             rst_n,
  skt_in_if.sink           in_ch,
  skt_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [CAP_W-1:0] cfg_wdata
);

  cmd_t cmd;
  sts_t sts;
  logic in_ready;

  assign in_ch.ready = in_ready;

  skt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  skt_datapath #(
    .DEPTH     (DEPTH),
    .KEY_BITS  (KEY_BITS),
    .LINE_BITS (LINE_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_operation (in_ch.operation),
    .in_key       (in_ch.key),
    .in_line_no   (in_ch.line_no),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .cmd          (cmd),
    .sts          (sts),
    .out_ch       (out_ch)
  );

endmodule

// ===== rtl/skt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module skt_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/skt_datapath.sv =====
// Datapath of the sorted key table: item and config registers, search bounds,
// shift pointer, entry RAMs and the result register. Depends on skt_pkg, skt_ram, skt_out_if.
module skt_datapath import skt_pkg::*; #(
  parameter int DEPTH     = 256,
  parameter int KEY_BITS  = 32,
  parameter int LINE_BITS = 24
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [OP_W-1:0]      in_operation,
  input  logic [IN_KEY_W-1:0]  in_key,
  input  logic [IN_LINE_W-1:0] in_line_no,
  input  logic                 cfg_we,
  input  logic [CAP_W-1:0]     cfg_wdata,
  input  cmd_t                 cmd,
  output sts_t                 sts,
  skt_out_if.source            out_ch
);

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  logic [OP_W-1:0]      op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [LINE_BITS-1:0] line_r;
  logic [CAP_W-1:0]     cap_r;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     lo_r;
  logic [CNT_W-1:0]     hi_r;
  logic [CNT_W-1:0]     mid_r;
  logic [CNT_W-1:0]     ptr_r;
  logic [CNT_W-1:0]     waddr_r;
  logic                 wpend_r;
  logic                 hit_r;
  logic [LINE_BITS-1:0] hit_line_r;
  logic                 out_valid_r;
  logic [STATUS_W-1:0]  status_r;
  logic [IN_LINE_W-1:0] line_out_r;

  logic [CNT_W-1:0]     mid;
  logic [CNT_W-1:0]     ptr_dec;
  logic [CMP_W-1:0]     cap_ext;
  logic [CMP_W-1:0]     cap_eff;
  logic                 ram_we;
  logic [ADDR_W-1:0]    ram_waddr;
  logic [ADDR_W-1:0]    ram_raddr;
  logic [KEY_BITS-1:0]  key_wdata;
  logic [LINE_BITS-1:0] line_wdata;
  logic [KEY_BITS-1:0]  key_rdata;
  logic [LINE_BITS-1:0] line_rdata;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign ptr_dec = ptr_r - CNT_W'(1);
  assign cap_ext = CMP_W'(cap_r);
  assign cap_eff = (cap_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : cap_ext;

  assign ram_we     = (cmd.shift_step && wpend_r) || cmd.write_new;
  assign ram_waddr  = cmd.write_new ? lo_r[ADDR_W-1:0] : waddr_r[ADDR_W-1:0];
  assign key_wdata  = cmd.write_new ? key_r : key_rdata;
  assign line_wdata = cmd.write_new ? line_r : line_rdata;
  assign ram_raddr  = cmd.probe ? mid[ADDR_W-1:0] : ptr_dec[ADDR_W-1:0];

  skt_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_wdata),
    .raddr (ram_raddr),
    .rdata (key_rdata)
  );

  skt_ram #(.WIDTH(LINE_BITS), .DEPTH(DEPTH)) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (line_wdata),
    .raddr (ram_raddr),
    .rdata (line_rdata)
  );

  assign sts.is_insert  = (op_r == OP_INSERT);
  assign sts.is_clear   = (op_r == OP_CLEAR);
  assign sts.bad_line   = (line_r == '0);
  assign sts.srch_more  = (lo_r < hi_r);
  assign sts.hit        = hit_r;
  assign sts.full       = (CMP_W'(count_r) >= cap_eff);
  assign sts.shift_done = (ptr_r == lo_r) && !wpend_r;
  assign sts.out_busy   = out_valid_r && !out_ch.ready;

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = status_r;
  assign out_ch.line_out = line_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r       <= CAP_RESET;
      count_r     <= '0;
      wpend_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (cmd.clear_cnt) begin
        count_r <= '0;
      end else if (cmd.write_new) begin
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.shift_init) begin
        wpend_r <= 1'b0;
      end else if (cmd.shift_step) begin
        wpend_r <= (ptr_r != lo_r);
      end
      if (cmd.resp) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_operation;
      key_r  <= KEY_BITS'(in_key);
      line_r <= LINE_BITS'(in_line_no);
    end
    if (cmd.srch_init) begin
      lo_r  <= '0;
      hi_r  <= count_r;
      hit_r <= 1'b0;
    end else if (cmd.cmp) begin
      if (key_rdata < key_r) begin
        lo_r <= mid_r + CNT_W'(1);
      end else begin
        hi_r <= mid_r;
      end
      if (key_rdata == key_r) begin
        hit_r      <= 1'b1;
        hit_line_r <= line_rdata;
      end
    end
    if (cmd.probe) begin
      mid_r <= mid;
    end
    if (cmd.shift_init) begin
      ptr_r <= count_r;
    end else if (cmd.shift_step && (ptr_r != lo_r)) begin
      waddr_r <= ptr_r;
      ptr_r   <= ptr_dec;
    end
    if (cmd.resp) begin
      status_r <= cmd.code;
      if (cmd.code == ST_DUPLICATE || cmd.code == ST_FOUND) begin
        line_out_r <= IN_LINE_W'(hit_line_r);
      end else begin
        line_out_r <= '0;
      end
    end
  end

endmodule

// ===== rtl/skt_ctrl.sv =====
// Controller of the sorted key table: sequences decode, binary search, shift and response.
// Depends on skt_pkg for states, codes and command/status structs.
module skt_ctrl import skt_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t              state_r, state_nxt;
  logic [STATUS_W-1:0] code_r, code_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      code_r  <= ST_CLEARED;
    end else begin
      state_r <= state_nxt;
      code_r  <= code_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    code_nxt  = code_r;
    in_ready  = 1'b0;
    cmd       = '0;
    cmd.code  = code_r;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (sts.is_clear) begin
          cmd.clear_cnt = 1'b1;
          code_nxt      = ST_CLEARED;
          state_nxt     = S_RESP;
        end else if (sts.is_insert && sts.bad_line) begin
          code_nxt  = ST_CLEARED;
          state_nxt = S_RESP;
        end else begin
          cmd.srch_init = 1'b1;
          state_nxt     = S_PROBE;
        end
      end
      S_PROBE: begin
        if (sts.srch_more) begin
          cmd.probe = 1'b1;
          state_nxt = S_CMP;
        end else if (sts.hit) begin
          code_nxt  = sts.is_insert ? ST_DUPLICATE : ST_FOUND;
          state_nxt = S_RESP;
        end else if (!sts.is_insert) begin
          code_nxt  = ST_NOT_FOUND;
          state_nxt = S_RESP;
        end else if (sts.full) begin
          code_nxt  = ST_FULL;
          state_nxt = S_RESP;
        end else begin
          cmd.shift_init = 1'b1;
          state_nxt      = S_SHIFT;
        end
      end
      S_CMP: begin
        cmd.cmp   = 1'b1;
        state_nxt = S_PROBE;
      end
      S_SHIFT: begin
        if (sts.shift_done) begin
          cmd.write_new = 1'b1;
          code_nxt      = ST_INSERTED;
          state_nxt     = S_RESP;
        end else begin
          cmd.shift_step = 1'b1;
        end
      end
      S_RESP: begin
        if (!sts.out_busy) begin
          cmd.resp  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule
